### design/ladder_keypad_debounce_assert.svh
// Assertion macros shared by the keypad debounce RTL.
`ifndef LADDER_KEYPAD_DEBOUNCE_ASSERT_SVH
`define LADDER_KEYPAD_DEBOUNCE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define LKD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkd assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define LKD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkd assertion failed");
`else
`define LKD_ASSERT_IMPL(lbl, ante, cons)
`define LKD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/lkd_pkg.sv
// Package: types, constants and helpers of the ladder keypad debouncer.
package lkd_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int SAMPLE_W    = 12;
    localparam int CNT_W       = 16;
    localparam int EVT_W       = 3;
    localparam int WIN_W       = NUM_BUTTONS * SAMPLE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = WIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGHS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd10;
    localparam logic [EVT_W-1:0] EVT_NONE    = 3'd0;

    typedef logic [NUM_BUTTONS-1:0] btn_vec_t;
    typedef logic [SAMPLE_W-1:0]    sample_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [EVT_W-1:0]       event_t;
    typedef logic [WIN_W-1:0]       windows_t;

    // Window match result handed from the comparator to the counter bank.
    typedef struct packed {
        logic     any;
        btn_vec_t onehot;
    } hit_t;

    // Button number of a single newly set bit, none otherwise.
    function automatic event_t event_code(input btn_vec_t rose);
        event_t code;
        code = EVT_NONE;
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            if (rose == btn_vec_t'(1 << k))
            begin
                code = EVT_W'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

### design/ladder_keypad_debounce.sv
// Top level of the five-button resistor-ladder keypad debouncer.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------
//  input   | in_valid / in_stall        | sample (12b)
//  output  | out_valid / out_stall      | pressed_buttons (5b), press_event (3b)
//  config  | cfg_wr_en                  | cfg_index (2b), cfg_data (60b)
//
// One transaction per cycle sustained while out_stall stays low; an accepted sample is
// held in the input register, then compared and counted into the result register.
// Counter state and the result register advance together, in order.
// An output stall holds the result; the input register keeps accepting until it
// holds a sample that cannot move on, then in_stall rises in the same cycle.
// Reset clears handshake state, counters, debounced bits and the config
// registers (limit resets to 10).
module ladder_keypad_debounce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lkd_pkg::sample_t                    sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lkd_pkg::btn_vec_t                   pressed_buttons,
    output lkd_pkg::event_t                     press_event,
    input  logic                                cfg_wr_en,
    input  logic [lkd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lkd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lkd_pkg::*;

    // configuration registers
    windows_t lows_reg;
    windows_t highs_reg;
    count_t   limit_reg;

    // input stage
    logic     s1_valid_reg;
    sample_t  sample_reg;

    // result stage
    logic     out_valid_reg;
    btn_vec_t pressed_reg;
    event_t   event_reg;

    logic     advance;
    logic     in_take;
    hit_t     hit;
    btn_vec_t bits_next;
    btn_vec_t rose;

    // The input stage moves into the result register when the latter is free
    // or is being drained this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lows_reg  <= '0;
            highs_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_LOWS:    lows_reg  <= cfg_data;
                REG_WINDOW_HIGHS:   highs_reg <= cfg_data;
                REG_DEBOUNCE_LIMIT: limit_reg <= cfg_data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
        end
    end

    lkd_match u_match (
        .sample       (sample_reg),
        .window_lows  (lows_reg),
        .window_highs (highs_reg),
        .hit          (hit)
    );

    lkd_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .hit       (hit),
        .limit     (limit_reg),
        .bits_next (bits_next),
        .rose      (rose)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pressed_reg <= bits_next;
            event_reg   <= event_code(rose);
        end
    end

    assign out_valid       = out_valid_reg;
    assign pressed_buttons = pressed_reg;
    assign press_event     = event_reg;

    `include "ladder_keypad_debounce_assert.svh"

    // a stall is only raised with a sample waiting
    `LKD_ASSERT_IMPL(a_stall_has_item, in_stall, s1_valid_reg)
    // a waiting sample that cannot move stays put
    `LKD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance,
                     s1_valid_reg && $stable(sample_reg))
    // every moved sample produces a result
    `LKD_ASSERT_NEXT(a_adv_result, advance, out_valid_reg)
    // a press event implies some bit is set in the same result
    `LKD_ASSERT_IMPL(a_evt_has_bit, out_valid_reg && (event_reg != EVT_NONE),
                     pressed_reg != '0)

endmodule

### design/lkd_match.sv
// Window comparator: strict bounds, lowest button number wins.
module lkd_match (
    input  lkd_pkg::sample_t  sample,
    input  lkd_pkg::windows_t window_lows,
    input  lkd_pkg::windows_t window_highs,
    output lkd_pkg::hit_t     hit
);
    import lkd_pkg::*;

    btn_vec_t in_win;

    always_comb
    begin
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            in_win[k] = (window_lows[k*SAMPLE_W +: SAMPLE_W] < sample) &&
                        (sample < window_highs[k*SAMPLE_W +: SAMPLE_W]);
        end
    end

    // priority select
    always_comb
    begin
        hit.any    = 1'b0;
        hit.onehot = '0;
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            if (in_win[k] && !hit.any)
            begin
                hit.onehot[k] = 1'b1;
                hit.any       = 1'b1;
            end
        end
    end

endmodule

### design/lkd_state.sv
// Counter bank and debounced state bits.
module lkd_state (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  lkd_pkg::hit_t     hit,
    input  lkd_pkg::count_t   limit,
    output lkd_pkg::btn_vec_t bits_next,
    output lkd_pkg::btn_vec_t rose
);
    import lkd_pkg::*;

    count_t   cnt_reg [NUM_BUTTONS];
    count_t   cnt_next [NUM_BUTTONS];
    btn_vec_t bits_reg;

    always_comb
    begin
        count_t c_inc;
        for (int k = 0; k < NUM_BUTTONS; k++) begin
            c_inc = (cnt_reg[k] >= limit) ? limit : cnt_reg[k] + 16'd1;
            if (!hit.any)
            begin
                cnt_next[k]  = '0;
                bits_next[k] = 1'b0;
            end
            else if (hit.onehot[k])
            begin
                cnt_next[k]  = c_inc;
                bits_next[k] = (c_inc >= limit);
            end
            else
            begin
                cnt_next[k]  = cnt_reg[k];
                bits_next[k] = bits_reg[k];
            end
        end
    end

    assign rose = bits_next & ~bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                cnt_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            bits_reg <= bits_next;
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    `include "ladder_keypad_debounce_assert.svh"

    // only the hit button can gain its bit on one update
    `LKD_ASSERT_NEXT(a_one_rise, advance, $countones(bits_reg & ~$past(bits_reg)) <= 1)
    // a miss clears every bit
    `LKD_ASSERT_NEXT(a_miss_clears, advance && !hit.any, bits_reg == '0)
    // a hit leaves the other buttons' bits alone
    `LKD_ASSERT_IMPL(a_hit_keeps_others, advance && hit.any,
                     (bits_next & ~hit.onehot) == (bits_reg & ~hit.onehot))

endmodule

### sim/tb_top.sv
// Testbench for the ladder keypad debouncer: ladder stimulus, debounce predictor, checking.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // Watchdog bound, set with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 200;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_LOGGED   = 100;
    // Nominal spacing of the ladder steps over the 12-bit ADC range.
    localparam int LADDER_STEP  = 819;

    // Index 3 is not a register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Neither rail can ever fall inside a window (both bounds are exclusive).
    localparam sample_t SAMPLE_FLOOR = '0;
    localparam sample_t SAMPLE_TOP   = '1;

    typedef struct packed {
        btn_vec_t pressed;
        event_t   evt;
    } keypad_result_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    sample_t               sample    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    btn_vec_t              pressed_buttons;
    event_t                press_event;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ladder_keypad_debounce dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: mirror of the config registers and the debouncer
    // ------------------------------------------------------------------
    windows_t cfg_lows   = '0;
    windows_t cfg_highs  = '0;
    count_t   cfg_limit  = LIMIT_RESET;
    count_t   btn_count [NUM_BUTTONS] = '{default: '0};
    btn_vec_t held_bits  = '0;

    sample_t        pending_samples[$];
    keypad_result_t expected_results[$];

    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    bit          in_fire      = 1'b0;
    bit          long_hold_go = 1'b0;

    task automatic log_error(input string msg);
        // Count every failure but keep the log bounded on a badly broken build.
        if (error_count < MAX_LOGGED)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // One tick of the debouncer: window match with button 1 first, the
    // matching counter saturates at the limit, a miss clears everything.
    function automatic keypad_result_t keypad_predict(input sample_t s);
        keypad_result_t r;
        btn_vec_t       prior;
        btn_vec_t       rose;
        count_t         c;
        int             hit;
        prior = held_bits;
        hit   = -1;
        for (int k = 0; k < NUM_BUTTONS; k++)
        begin
            if (hit < 0 && cfg_lows[k*SAMPLE_W +: SAMPLE_W] < s
                && s < cfg_highs[k*SAMPLE_W +: SAMPLE_W])
                hit = k;
        end
        if (hit >= 0)
        begin
            c = btn_count[hit];
            c = (c >= cfg_limit) ? cfg_limit : c + 1'b1;
            btn_count[hit] = c;
            // With a zero limit the count stays 0 and the bit sets at once.
            held_bits[hit] = (c >= cfg_limit);
        end
        else
        begin
            foreach (btn_count[k])
                btn_count[k] = '0;
            held_bits = '0;
        end
        rose = held_bits & ~prior;
        case (rose)
            5'b00001: r.evt = 3'd1;
            5'b00010: r.evt = 3'd2;
            5'b00100: r.evt = 3'd3;
            5'b01000: r.evt = 3'd4;
            5'b10000: r.evt = 3'd5;
            default:  r.evt = EVT_NONE;
        endcase
        r.pressed = held_bits;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps between them.
    // A stalled transaction keeps valid and payload untouched.
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_samples.size() != 0)
            begin
                sample   <= pending_samples.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    // A third of the bursts run straight into the next one.
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: its own stall pattern, switching mode now and then,
    // plus one long hold-off so the pipe fills and in_stall rises.
    // ------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    int unsigned stall_tick = 0;
    bit          hold_done  = 1'b0;

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (long_hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
                default:     out_stall <= (stall_tick % 4 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input transaction, check each
    // accepted output transaction against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        keypad_result_t want;
        cycle_count++;
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
            expected_results.push_back(keypad_predict(sample));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                log_error($sformatf("unexpected result pressed=%b event=%0d",
                                    pressed_buttons, press_event));
            else
            begin
                want = expected_results.pop_front();
                if (pressed_buttons !== want.pressed)
                    log_error($sformatf("pressed_buttons got %b want %b",
                                        pressed_buttons, want.pressed));
                if (press_event !== want.evt)
                    log_error($sformatf("press_event got %0d want %0d",
                                        press_event, want.evt));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_WINDOW_LOWS:    cfg_lows  = data;
            REG_WINDOW_HIGHS:   cfg_highs = data;
            REG_DEBOUNCE_LIMIT: cfg_limit = data[CNT_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_keypad(input windows_t lo, input windows_t hi,
                                  input count_t lim);
        write_reg(REG_WINDOW_LOWS, lo);
        write_reg(REG_WINDOW_HIGHS, hi);
        write_reg(REG_DEBOUNCE_LIMIT, CFG_DATA_W'(lim));
    endtask

    // Five disjoint windows, one per ladder step, in either voltage order.
    task automatic build_ladder(output windows_t lo, output windows_t hi);
        int seg;
        int base;
        bit flip;
        flip = $urandom_range(0, 1);
        lo   = '0;
        hi   = '0;
        for (int k = 0; k < NUM_BUTTONS; k++)
        begin
            seg  = flip ? NUM_BUTTONS - 1 - k : k;
            base = seg * LADDER_STEP;
            lo[k*SAMPLE_W +: SAMPLE_W] = sample_t'(base + $urandom_range(0, 60));
            hi[k*SAMPLE_W +: SAMPLE_W] = sample_t'(base + LADDER_STEP - 1
                                                   - $urandom_range(0, 60));
        end
    endtask

    // n samples inside the window of button b (0-based); anything if empty.
    task automatic queue_hold(input int b, input int n);
        int lo;
        int hi;
        lo = cfg_lows[b*SAMPLE_W +: SAMPLE_W];
        hi = cfg_highs[b*SAMPLE_W +: SAMPLE_W];
        repeat (n)
        begin
            if (hi > lo + 1)
                pending_samples.push_back(sample_t'($urandom_range(lo + 1, hi - 1)));
            else
                pending_samples.push_back(sample_t'($urandom_range(0, 4095)));
        end
    endtask

    task automatic queue_release();
        pending_samples.push_back($urandom_range(0, 1) ? SAMPLE_TOP : SAMPLE_FLOOR);
    endtask

    // Mostly key holds long enough to debounce, sometimes rolled over to
    // another key, sometimes released; the rest is raw ADC noise.
    task automatic queue_random(input int n);
        int made;
        int b;
        int run;
        int cap;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                b   = $urandom_range(0, NUM_BUTTONS - 1);
                cap = (cfg_limit > 12) ? 14 : int'(cfg_limit) + 2;
                run = $urandom_range(1, cap);
                queue_hold(b, run);
                made += run;
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_release();
                    made++;
                end
            end
            else
            begin
                run = $urandom_range(1, 5);
                repeat (run)
                    pending_samples.push_back(sample_t'($urandom_range(0, 4095)));
                made += run;
            end
        end
    endtask

    // Sender pause: nothing queued, nothing offered, nothing outstanding.
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        windows_t lo_w;
        windows_t hi_w;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: every window is empty, so nothing may ever press.
        pending_samples.push_back(SAMPLE_FLOOR);
        pending_samples.push_back(SAMPLE_TOP);
        pending_samples.push_back(12'h800);
        pending_samples.push_back(12'hAAA);
        pending_samples.push_back(12'h555);
        queue_random(15);
        wait_idle();

        // Shortest debounce: one in-window tick presses.
        build_ladder(lo_w, hi_w);
        program_keypad(lo_w, hi_w, 16'd1);
        queue_random(90);
        wait_idle();

        // Limit 3, directed: rise, saturation, a second key held on top of
        // the first, a key that never makes it, release at both rails.
        build_ladder(lo_w, hi_w);
        program_keypad(lo_w, hi_w, 16'd3);
        queue_hold(0, 4);
        queue_hold(4, 3);
        queue_hold(2, 2);
        pending_samples.push_back(SAMPLE_FLOOR);
        pending_samples.push_back(SAMPLE_TOP);
        queue_hold(1, 3);
        queue_random(100);
        // Receiver holds off while the sender keeps offering.
        long_hold_go = 1'b1;
        wait_idle();

        // Overlapping and partly empty windows: lowest button must win.
        for (int k = 0; k < NUM_BUTTONS; k++)
        begin
            lo_w[k*SAMPLE_W +: SAMPLE_W] = sample_t'($urandom_range(0, 2400));
            hi_w[k*SAMPLE_W +: SAMPLE_W] = sample_t'($urandom_range(1200, 4095));
        end
        program_keypad(lo_w, hi_w, count_t'($urandom_range(2, 8)));
        queue_random(90);
        wait_idle();

        // Longest debounce: counters climb but never reach it here.
        build_ladder(lo_w, hi_w);
        program_keypad(lo_w, hi_w, 16'hFFFF);
        queue_random(60);
        wait_idle();

        // Zero limit presses on the first tick; a write to the spare index
        // must not disturb anything.
        write_reg(REG_DEBOUNCE_LIMIT, '0);
        write_reg(REG_SPARE, CFG_DATA_W'({$urandom(), $urandom()}));
        queue_release();
        queue_hold(3, 2);
        queue_random(80);
        wait_idle();

        // Widest windows: all five cover 1..4094, button 1 always wins.
        program_keypad('0, '1, 16'd2);
        queue_random(70);
        wait_idle();

        // All-ones bounds: every window empty again.
        program_keypad('1, '1, 16'd5);
        queue_random(40);
        wait_idle();

        build_ladder(lo_w, hi_w);
        program_keypad(lo_w, hi_w, 16'd6);
        queue_random(90);
        wait_idle();

        // Let any stray result surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_results.size()));

        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/lkd_pkg.sv
design/lkd_match.sv
design/lkd_state.sv
design/ladder_keypad_debounce.sv
sim/tb_top.sv
